// ===== src/trlyt_pkg.sv =====
// package: constants, atan table and stage types for the yaw tracker
`timescale 1ns / 1ps

package trlyt_pkg;

	// cordic depth, 8 to 24
	localparam int ANGLE_ITERATIONS = 16;

	// cordic datapath width: 25-bit difference scaled by 2^24 plus gain headroom
	localparam int CW = 52;
	// angle accumulator width in 1/32768 degree
	localparam int ZW = 25;

	localparam logic signed [ZW-1:0] DEG90_FINE     = ZW'(2949120);
	localparam logic [16:0]          TURN_SPEED_RST = 17'd23040;
	localparam int                   HALF_TURN      = 23040;
	localparam int                   FULL_TURN      = 46080;

	// one cordic stage payload
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic signed [15:0]   yaw;
		logic [16:0]          step;
		logic                 act;
	} rot_t;

	// arctan(2^-i) in 1/32768 degree
	function automatic logic signed [ZW-1:0] atan_fine(input int i);
		logic signed [ZW-1:0] a;
		unique case (i)
			0:  a = ZW'(1474560);
			1:  a = ZW'(870484);
			2:  a = ZW'(459940);
			3:  a = ZW'(233473);
			4:  a = ZW'(117189);
			5:  a = ZW'(58652);
			6:  a = ZW'(29333);
			7:  a = ZW'(14667);
			8:  a = ZW'(7334);
			9:  a = ZW'(3667);
			10: a = ZW'(1833);
			11: a = ZW'(917);
			12: a = ZW'(458);
			13: a = ZW'(229);
			14: a = ZW'(115);
			15: a = ZW'(57);
			16: a = ZW'(29);
			17: a = ZW'(14);
			18: a = ZW'(7);
			19: a = ZW'(4);
			20: a = ZW'(2);
			21: a = ZW'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== src/turn_rate_limited_yaw_tracker_top.sv =====
// top level: pipelined cordic heading tracker with turn-rate clamp
//
//  channel  dir  handshake                  payload
//  s_axis   in   s_axis_tvalid/tready       tdata: owner_x, owner_z, target_x, target_z,
//                                           current_yaw, frame_time; tuser: target_valid
//  m_axis   out  m_axis_tvalid/tready       tdata: new_yaw; tuser: turned
//  cfg      in   cfg_wr_en                  cfg_wr_data: turn_speed
//
//  one request per cycle while m_axis is not stalled; the cordic is unrolled,
//  one iteration per stage.
//  arst_n clears all stage valid bits and loads turn_speed with 180 degrees per second.
//  every stage holds while the next one is full and stalled, so empty stages
//  keep filling and a new request is taken while a result waits at the output.
`timescale 1ns / 1ps

module turn_rate_limited_yaw_tracker_top
	import trlyt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [16:0]  cfg_wr_data,   // turn_speed
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// owner_x[23:0], owner_z[47:24], target_x[71:48], target_z[95:72],
	// current_yaw[111:96], frame_time[127:112]
	input  logic [127:0] s_axis_tdata,
	input  logic         s_axis_tuser,  // target_valid
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [23:0]  m_axis_tdata,  // new_yaw[16:0], zero fill
	output logic         m_axis_tuser   // turned
);

	localparam int N = ANGLE_ITERATIONS;

	logic [16:0] turn_speed_q;

	// stage 1: differences and step product
	logic                 vld_s1;
	logic signed [24:0]   dx_s1, dz_s1;
	logic signed [15:0]   yaw_s1;
	logic [16:0]          step_s1;
	logic                 act_s1;
	logic                 rdy_s1;

	// stage 2 and cordic stages
	rot_t                 iter_s [0:N];
	logic [N:0]           ivld_s;
	logic [N:0]           irdy;

	// stage 3: raw error and saturated limit
	logic                 vld_s3, rdy_s3;
	logic signed [17:0]   dlt_s3;
	logic [14:0]          lim_s3;
	logic signed [15:0]   yaw_s3;
	logic                 act_s3;

	// stage 4: wrapped error
	logic                 vld_s4, rdy_s4;
	logic signed [15:0]   wrp_s4;
	logic [14:0]          lim_s4;
	logic signed [15:0]   yaw_s4;
	logic                 act_s4;

	// stage 5: output register
	logic                 vld_s5, rdy_s5;
	logic [16:0]          yaw_s5;
	logic                 act_s5;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_speed_q <= TURN_SPEED_RST;
		end else if (cfg_wr_en) begin
			turn_speed_q <= cfg_wr_data;
		end
	end

	// ready chain from the output back
	assign rdy_s5 = !vld_s5 || m_axis_tready;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign irdy[N] = !ivld_s[N] || rdy_s3;
	for (genvar r = 0; r < N; r++) begin : g_rdy
		assign irdy[r] = !ivld_s[r] || irdy[r+1];
	end
	assign rdy_s1 = !vld_s1 || irdy[0];
	assign s_axis_tready = rdy_s1;

	// stage 1 logic
	logic signed [23:0] own_x, own_z, tgt_x, tgt_z;
	logic [32:0]        prod;
	always_comb begin
		own_x = s_axis_tdata[23:0];
		own_z = s_axis_tdata[47:24];
		tgt_x = s_axis_tdata[71:48];
		tgt_z = s_axis_tdata[95:72];
		prod  = {16'b0, turn_speed_q} * {17'b0, s_axis_tdata[127:112]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			dx_s1   <= 25'(tgt_x) - 25'(own_x);
			dz_s1   <= 25'(tgt_z) - 25'(own_z);
			yaw_s1  <= s_axis_tdata[111:96];
			step_s1 <= prod[32:16];
			act_s1  <= s_axis_tuser;
		end
	end

	// stage 2: scale and quarter-turn pre-rotation
	rot_t                 pre;
	logic signed [CW-1:0] xs0, ys0;
	always_comb begin
		xs0      = {{(CW-49){dz_s1[24]}}, dz_s1, 24'b0};
		ys0      = {{(CW-49){dx_s1[24]}}, dx_s1, 24'b0};
		pre.yaw  = yaw_s1;
		pre.step = step_s1;
		pre.act  = act_s1 && ((dx_s1 != '0) || (dz_s1 != '0));
		pre.x    = xs0;
		pre.y    = ys0;
		pre.z    = '0;
		if (xs0 < 0) begin
			if (ys0 >= 0) begin
				pre.x = ys0;
				pre.y = -xs0;
				pre.z = DEG90_FINE;
			end else begin
				pre.x = -ys0;
				pre.y = xs0;
				pre.z = -DEG90_FINE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ivld_s[0] <= 1'b0;
		end else if (irdy[0]) begin
			ivld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (irdy[0]) begin
			iter_s[0] <= pre;
		end
	end

	// cordic vectoring, one iteration per stage
	for (genvar k = 0; k < N; k++) begin : g_iter
		rot_t                 nxt;
		logic signed [CW-1:0] xi, yi, xsh, ysh;
		logic signed [ZW-1:0] zi;

		always_comb begin
			xi  = iter_s[k].x;
			yi  = iter_s[k].y;
			zi  = iter_s[k].z;
			xsh = xi >>> k;
			ysh = yi >>> k;
			nxt = iter_s[k];
			if (!yi[CW-1]) begin
				nxt.x = xi + ysh;
				nxt.y = yi - xsh;
				nxt.z = zi + atan_fine(k);
			end else begin
				nxt.x = xi - ysh;
				nxt.y = yi + xsh;
				nxt.z = zi - atan_fine(k);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ivld_s[k+1] <= 1'b0;
			end else if (irdy[k+1]) begin
				ivld_s[k+1] <= ivld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (irdy[k+1]) begin
				iter_s[k+1] <= nxt;
			end
		end
	end

	// stage 3: round heading, form error, saturate step
	logic signed [ZW-1:0] zr;
	logic signed [16:0]   desired;
	always_comb begin
		zr      = iter_s[N].z + ZW'(128);
		desired = zr[ZW-1:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= ivld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			dlt_s3 <= 18'(desired) - 18'(iter_s[N].yaw);
			lim_s3 <= (iter_s[N].step > 17'(HALF_TURN)) ? 15'(HALF_TURN)
			                                             : iter_s[N].step[14:0];
			yaw_s3 <= iter_s[N].yaw;
			act_s3 <= iter_s[N].act;
		end
	end

	// stage 4: wrap error into half a turn
	logic signed [17:0] wrp;
	always_comb begin
		wrp = dlt_s3;
		if (dlt_s3 > 18'sd23040) begin
			wrp = dlt_s3 - 18'(FULL_TURN);
		end else if (dlt_s3 < -18'sd23040) begin
			wrp = dlt_s3 + 18'(FULL_TURN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (rdy_s4) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			wrp_s4 <= wrp[15:0];
			lim_s4 <= lim_s3;
			yaw_s4 <= yaw_s3;
			act_s4 <= act_s3;
		end
	end

	// stage 5: clamp and apply
	logic signed [16:0] lim17, clamped, sum;
	always_comb begin
		lim17   = {2'b0, lim_s4};
		clamped = 17'(wrp_s4);
		if (clamped > lim17) begin
			clamped = lim17;
		end else if (clamped < -lim17) begin
			clamped = -lim17;
		end
		sum = 17'(yaw_s4);
		if (act_s4) begin
			sum = 17'(yaw_s4) + clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (rdy_s5) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			yaw_s5 <= sum;
			act_s5 <= act_s4;
		end
	end

	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata  = {7'b0, yaw_s5};
	assign m_axis_tuser  = act_s5;

	// checks
	a_wrap_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (wrp_s4 <= 16'sd23040) && (wrp_s4 >= -16'sd23040))
		else $error("wrapped error outside half a turn");

	a_lim_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (lim_s3 <= 15'(HALF_TURN)))
		else $error("step limit not saturated");

	a_stall_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !rdy_s4) |=> vld_s4)
		else $error("stalled stage dropped its item");

	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (vld_s5 && !m_axis_tready))
		else $error("input blocked without a stalled output");

endmodule

// ===== tb/sv/yaw_track_checker.sv =====
// checker: predicts each yaw update from the request and compares the returned results
`timescale 1ns / 1ps

module yaw_track_checker
	import trlyt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [16:0]  cfg_wr_data,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,
	input  logic         s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [23:0]  m_axis_tdata,
	input  logic         m_axis_tuser,
	output int           fail_count,
	output int           outstanding
);

	typedef struct packed {
		logic [16:0] new_yaw;
		logic        turned;
	} yaw_result_t;

	// arctan(2^-i) in 1/32768 degree
	localparam longint ATAN_STEP [24] = '{
		1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
		7334, 3667, 1833, 917, 458, 229, 115, 57,
		29, 14, 7, 4, 2, 1, 0, 0
	};

	yaw_result_t expected_yaw_q [$];
	logic [16:0] speed_copy;
	int          error_tally = 0;

	// atan2(dx, dz) in 1/128 degree by vectoring rotations
	function automatic longint heading_of(input longint dx, input longint dz);
		longint x, y, z, t, xs, ys;
		x = dz * 64'sd16777216;
		y = dx * 64'sd16777216;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = longint'(DEG90_FINE);
			end else begin
				t = x; x = -y; y = t; z = -longint'(DEG90_FINE);
			end
		end
		for (int i = 0; i < ANGLE_ITERATIONS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + ATAN_STEP[i];
			end else begin
				x = x - ys; y = y + xs; z = z - ATAN_STEP[i];
			end
		end
		return (z + 128) >>> 8;
	endfunction

	// wrapped error clamped to the per-frame turn budget
	function automatic yaw_result_t next_yaw(input logic tv, input logic [127:0] d,
			input logic [16:0] spd);
		longint dx, dz, yaw, err, lim, sum;
		yaw_result_t r;
		dx  = longint'($signed(d[71:48])) - longint'($signed(d[23:0]));
		dz  = longint'($signed(d[95:72])) - longint'($signed(d[47:24]));
		yaw = longint'($signed(d[111:96]));
		if (!tv || (dx == 0 && dz == 0)) begin
			r.new_yaw = yaw[16:0];
			r.turned  = 1'b0;
			return r;
		end
		err = heading_of(dx, dz) - yaw;
		while (err > HALF_TURN)
			err = err - FULL_TURN;
		while (err < -HALF_TURN)
			err = err + FULL_TURN;
		lim = (longint'(spd) * longint'(d[127:112])) >>> 16;
		if (lim > HALF_TURN)
			lim = HALF_TURN;
		if (err > lim)
			err = lim;
		if (err < -lim)
			err = -lim;
		sum = yaw + err;
		r.new_yaw = sum[16:0];
		r.turned  = 1'b1;
		return r;
	endfunction

	// track the register, queue predictions, compare results in order
	always @(posedge clk or negedge arst_n) begin
		yaw_result_t want;
		if (!arst_n) begin
			expected_yaw_q.delete();
			speed_copy  <= TURN_SPEED_RST;
			outstanding <= 0;
			fail_count  <= error_tally;
		end else begin
			if (cfg_wr_en)
				speed_copy <= cfg_wr_data;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_yaw_q.size() == 0) begin
					error_tally++;
					$display("%0t: unexpected result new_yaw %0d turned %0b", $time,
						$signed(m_axis_tdata[16:0]), m_axis_tuser);
				end else begin
					want = expected_yaw_q.pop_front();
					if (m_axis_tdata !== {7'b0, want.new_yaw}) begin
						error_tally++;
						$display("%0t: new_yaw expected %0d (%h) actual %0d (%h)", $time,
							$signed(want.new_yaw), {7'b0, want.new_yaw},
							$signed(m_axis_tdata[16:0]), m_axis_tdata);
					end
					if (m_axis_tuser !== want.turned) begin
						error_tally++;
						$display("%0t: turned expected %0b actual %0b", $time,
							want.turned, m_axis_tuser);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_yaw_q.push_back(next_yaw(s_axis_tuser, s_axis_tdata, speed_copy));
			outstanding <= expected_yaw_q.size();
			fail_count  <= error_tally;
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench top: clock, reset, request stimulus, turn-speed phases and verdict
`timescale 1ns / 1ps

module tb_top
	import trlyt_pkg::*;
();

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 235;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic [16:0]  cfg_wr_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [23:0]  m_axis_tdata;
	logic         m_axis_tuser;

	int fail_count;
	int outstanding;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int cycles = 0;

	turn_rate_limited_yaw_tracker_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	yaw_track_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// run time limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, outstanding);
			$display("status: fail");
			$finish;
		end
	end

	// present one request after random sender gaps, hold until accepted
	task automatic send_item(input logic tv, input logic [23:0] ox, input logic [23:0] oz,
			input logic [23:0] tx, input logic [23:0] tz, input logic [15:0] yaw,
			input logic [15:0] ft);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= tv;
		s_axis_tdata  <= {ft, yaw, tz, tx, oz, ox};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// random request: far or nearby targets, some aligned or coincident
	task automatic send_random();
		logic        tv;
		logic [23:0] ox, oz, tx, tz;
		logic [15:0] yaw, ft;
		int          base_x, base_z;
		tv = ($urandom_range(99) >= 8);
		base_x = int'($urandom_range(4194303)) - 2097152;
		base_z = int'($urandom_range(4194303)) - 2097152;
		ox = 24'(base_x);
		oz = 24'(base_z);
		tx = 24'(base_x + int'($urandom_range(4095)) - 2048);
		tz = 24'(base_z + int'($urandom_range(4095)) - 2048);
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				ox = 24'($urandom());
				oz = 24'($urandom());
				tx = 24'($urandom());
				tz = 24'($urandom());
			end
			7: begin
				tx = ox;
				tz = oz;
			end
			8: tx = ox;
			9: tz = oz;
			default: ;
		endcase
		if ($urandom_range(99) < 85)
			yaw = 16'(int'($urandom_range(46079)) - HALF_TURN);
		else
			yaw = 16'($urandom());
		if ($urandom_range(1) == 0)
			ft = 16'($urandom_range(4095));
		else
			ft = 16'($urandom());
		send_item(tv, ox, oz, tx, tz, yaw, ft);
	endtask

	// drain the pipeline, then load a new turn speed
	task automatic write_turn_speed(input logic [16:0] spd);
		s_axis_tvalid <= 1'b0;
		// let the count take in the request accepted at this edge
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (ANGLE_ITERATIONS + 14) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= spd;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		int speeds [8];
		int send_mode [4];
		int stall_mode [4];
		speeds     = '{92160, 0, 1, -1, 23040, -1, 65536, -1};
		send_mode  = '{0, 73, 0, 20};
		stall_mode = '{0, 0, 73, 20};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests at the reset turn speed, no idling
		send_item(0, 0, 0, 1000, 2000, 100, 4096);
		send_item(1, 12345, -6789, 12345, -6789, -500, 4096);
		send_item(1, 24'h800000, 0, 24'h7FFFFF, 0, 0, 65535);
		send_item(1, 24'h7FFFFF, 0, 24'h800000, 0, 0, 65535);
		send_item(1, 0, 24'h800000, 0, 24'h7FFFFF, 11520, 65535);
		send_item(1, 0, 24'h7FFFFF, 0, 24'h800000, 0, 65535);
		send_item(1, 500, 500, -300, -700, 0, 30000);
		send_item(1, -500, 500, 300, -700, 0, 30000);
		send_item(1, 0, 0, 1, 0, 0, 1092);
		send_item(1, 0, 0, 0, 1, 0, 1092);
		send_item(1, 0, 0, 256, 256, 16'h8000, 65535);
		send_item(1, 0, 0, -256, 256, 16'h7FFF, 65535);
		send_item(1, 0, 0, 0, -256, -23040, 65535);
		send_item(1, 0, 0, -256, 0, 23039, 65535);
		send_item(1, 0, 0, 256, 256, 0, 0);
		send_item(1, 0, 0, 256, 256, 0, 200);
		send_item(1, 24'hFFFFFF, 24'hFFFFFF, 24'h555555, 24'hAAAAAA, 16'h5555, 16'hAAAA);
		send_item(0, 0, 0, 0, 0, 16'h8000, 65535);
		send_item(0, 24'hAAAAAA, 24'h555555, 0, 0, 16'h7FFF, 0);

		// random phases across turn speeds and idle patterns
		for (int p = 0; p < 8; p++) begin
			if (speeds[p] < 0)
				write_turn_speed(17'($urandom_range(92160)));
			else
				write_turn_speed(17'(speeds[p]));
			send_idle_pct = send_mode[p % 4];
			stall_pct     = stall_mode[p % 4];
			repeat (PHASE_ITEMS) send_random();
		end

		s_axis_tvalid <= 1'b0;
		// let the count take in the request accepted at this edge
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (ANGLE_ITERATIONS + 24) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("%0t: %0d mismatches, %0d results outstanding", $time, fail_count,
				outstanding);
			$display("status: fail");
		end
		$finish;
	end

endmodule
